>>> rtl/pmt_pkg.sv
package pmt_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int PIN_CHARS   = 4;

    localparam int PIN_W = 8 * PIN_CHARS;
    localparam int LEN_W = $clog2(PIN_CHARS + 1);
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    localparam int DEF_CHARS = (PIN_CHARS < 4) ? PIN_CHARS : 4;

    typedef enum logic [1:0] {
        OP_AUTH   = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CHANGE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_DONE     = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_NO_ENTRY = 2'd2,
        STAT_NO_MATCH = 2'd3
    } t_status;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef struct packed {
        logic [PIN_W-1:0] pin;
        logic [LEN_W-1:0] len;
    } t_entry;

    // request broadcast to every cell
    typedef struct packed {
        logic       go;
        logic       ok;
        t_op        op;
        t_entry     entry;
        logic [3:0] idx;
        t_cnt       count;
    } t_cmd;

    // "1234" cut to the pin width
    function automatic t_entry def_entry();
        t_entry e;
        e = '0;
        for (int b = 0; b < DEF_CHARS; b++) begin
            e.pin[8*b +: 8] = 8'(8'h31 + b);
        end
        e.len = LEN_W'(DEF_CHARS);
        return e;
    endfunction

endpackage

>>> rtl/pmt_if.sv
interface pmt_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [31:0] pin_chars;
    logic [2:0] pin_length;
    logic [3:0] entry_index;

    modport source (output valid, opcode, pin_chars, pin_length, entry_index, input ready);
    modport sink   (input valid, opcode, pin_chars, pin_length, entry_index, output ready);
endinterface

interface pmt_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [3:0] match_index;
    logic [4:0] entry_count;

    modport source (output valid, status, match_index, entry_count, input ready);
    modport sink   (input valid, status, match_index, entry_count, output ready);
endinterface

>>> rtl/pmt_cell.sv
module pmt_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pmt_pkg::t_idx   i_index,
    input  pmt_pkg::t_cmd   i_cmd,
    input  pmt_pkg::t_entry i_key,
    input  pmt_pkg::t_entry i_next,
    input  logic            i_tok,
    output pmt_pkg::t_entry o_entry,
    output logic            o_tok,
    output logic            o_hit
);

    pmt_pkg::t_entry r_entry, n_entry;
    logic            r_tok;
    logic            w_live;

    always_comb begin
        int my;
        int cnt;
        my      = int'(i_index);
        cnt     = int'(i_cmd.count);
        n_entry = r_entry;
        if (i_cmd.go && i_cmd.ok) begin
            unique case (i_cmd.op)
                pmt_pkg::OP_ADD: begin
                    if (my == cnt) n_entry = i_cmd.entry;
                end
                pmt_pkg::OP_CHANGE: begin
                    if (my == int'(i_cmd.idx)) n_entry = i_cmd.entry;
                end
                pmt_pkg::OP_REMOVE: begin
                    // vacated last slot clears, later entries move down one
                    if (my == cnt - 1) begin
                        n_entry = '0;
                    end else if (my >= int'(i_cmd.idx) && my < cnt - 1) begin
                        n_entry = i_next;
                    end
                end
                pmt_pkg::OP_AUTH: begin
                    n_entry = r_entry;
                end
                default: n_entry = r_entry;
            endcase
        end
    end

    assign w_live = int'(i_index) < int'(i_cmd.count);
    assign o_hit  = r_tok && w_live && (r_entry == i_key);
    assign o_tok  = r_tok && !o_hit;
    assign o_entry = r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= (i_index == '0) ? pmt_pkg::def_entry() : '0;
            r_tok   <= 1'b0;
        end else begin
            r_entry <= n_entry;
            r_tok   <= i_tok;
        end
    end

endmodule

>>> rtl/pin_table_match_engine.sv
// channel  dir  handshake      payload
// i_req    in   valid/ready    opcode, pin_chars, pin_length, entry_index
// o_rsp    out  valid/ready    status, match_index, entry_count
//
// add, remove and change register their result at accept and pass it to the output register; authenticate
// walks a search token down the row of entry cells, one cell a cycle, until the first match
// or the last cell of the chain. one request at a time; a result waits in the output register
// while the next request is accepted. synchronous active-low reset loads the single entry 1234.
module pin_table_match_engine (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pmt_req_if.sink   i_req,
    pmt_rsp_if.source o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_RESP = 3'b100
    } t_state;

    t_state           r_state, n_state;
    pmt_pkg::t_cnt    r_count, n_count;
    pmt_pkg::t_idx    r_pos;
    pmt_pkg::t_entry  r_key;
    pmt_pkg::t_status r_st;
    logic [3:0]       r_mi;
    logic [4:0]       r_ec;
    logic             r_ov;
    pmt_pkg::t_status r_os;
    logic [3:0]       r_om;
    logic [4:0]       r_oe;

    pmt_pkg::t_cmd    w_cmd;
    pmt_pkg::t_status w_status;
    logic             w_accept;
    logic             w_hit_any;
    logic             w_load_out;

    pmt_pkg::t_entry  w_entry [pmt_pkg::MAX_ENTRIES];
    logic [pmt_pkg::MAX_ENTRIES-1:0] w_tok;
    logic [pmt_pkg::MAX_ENTRIES-1:0] w_hit;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;

    // request decode: saturate length, zero unused bytes
    always_comb begin
        logic [63:0] wide;
        logic [pmt_pkg::LEN_W-1:0] len;
        logic idx_ok;
        logic full;
        wide   = {32'h0, i_req.pin_chars};
        len    = (int'(i_req.pin_length) > pmt_pkg::PIN_CHARS)
               ? pmt_pkg::LEN_W'(pmt_pkg::PIN_CHARS)
               : pmt_pkg::LEN_W'(i_req.pin_length);
        idx_ok = int'(i_req.entry_index) < int'(r_count);
        full   = int'(r_count) >= pmt_pkg::MAX_ENTRIES;
        w_cmd.go    = w_accept;
        w_cmd.op    = pmt_pkg::t_op'(i_req.opcode);
        w_cmd.idx   = i_req.entry_index;
        w_cmd.count = r_count;
        w_cmd.entry.len = len;
        for (int b = 0; b < pmt_pkg::PIN_CHARS; b++) begin
            w_cmd.entry.pin[8*b +: 8] = (b < int'(len)) ? wide[8*b +: 8] : 8'h00;
        end
        w_cmd.ok = (w_cmd.op == pmt_pkg::OP_ADD) ? !full : idx_ok;

        n_count  = r_count;
        w_status = pmt_pkg::STAT_DONE;
        unique case (w_cmd.op)
            pmt_pkg::OP_ADD: begin
                if (w_cmd.ok) n_count = r_count + 1'b1;
                else          w_status = pmt_pkg::STAT_FULL;
            end
            pmt_pkg::OP_REMOVE: begin
                if (w_cmd.ok) n_count = r_count - 1'b1;
                else          w_status = pmt_pkg::STAT_NO_ENTRY;
            end
            pmt_pkg::OP_CHANGE: begin
                if (!w_cmd.ok) w_status = pmt_pkg::STAT_NO_ENTRY;
            end
            pmt_pkg::OP_AUTH: begin
                w_status = pmt_pkg::STAT_NO_MATCH;
            end
            default: w_status = pmt_pkg::STAT_DONE;
        endcase
    end

    for (genvar g = 0; g < pmt_pkg::MAX_ENTRIES; g++) begin : g_cell
        pmt_pkg::t_entry w_next;
        logic            w_tok_in;
        if (g == pmt_pkg::MAX_ENTRIES - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_entry[g+1];
        end
        if (g == 0) begin : g_first
            assign w_tok_in = w_accept && (w_cmd.op == pmt_pkg::OP_AUTH);
        end else begin : g_rest
            assign w_tok_in = w_tok[g-1];
        end
        pmt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (pmt_pkg::IDX_W'(g)),
            .i_cmd   (w_cmd),
            .i_key   (r_key),
            .i_next  (w_next),
            .i_tok   (w_tok_in),
            .o_entry (w_entry[g]),
            .o_tok   (w_tok[g]),
            .o_hit   (w_hit[g])
        );
    end

    assign w_hit_any  = |w_hit;
    assign w_load_out = (r_state == S_RESP) && (!r_ov || o_rsp.ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = (w_cmd.op == pmt_pkg::OP_AUTH) ? S_SCAN : S_RESP;
            end
            S_SCAN: begin
                if (w_hit_any || r_pos == pmt_pkg::IDX_W'(pmt_pkg::MAX_ENTRIES - 1))
                    n_state = S_RESP;
            end
            S_RESP: begin
                if (w_load_out) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= pmt_pkg::CNT_W'(1);
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) r_count <= n_count;
            if (w_load_out)       r_ov <= 1'b1;
            else if (o_rsp.ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key <= w_cmd.entry;
            r_pos <= '0;
            r_st  <= w_status;
            r_mi  <= 4'h0;
            r_ec  <= 5'(n_count);
        end else if (r_state == S_SCAN) begin
            // token sits in cell r_pos this cycle
            if (w_hit_any) begin
                r_st <= pmt_pkg::STAT_DONE;
                r_mi <= 4'(r_pos);
            end else begin
                r_pos <= r_pos + 1'b1;
            end
        end
        if (w_load_out) begin
            r_os <= r_st;
            r_om <= r_mi;
            r_oe <= r_ec;
        end
    end

    assign o_rsp.valid       = r_ov;
    assign o_rsp.status      = r_os;
    assign o_rsp.match_index = r_om;
    assign o_rsp.entry_count = r_oe;

endmodule
